@@ design/wfir_pkg.sv @@
// wfir_pkg: shared types, codes and fixed-point constants of the
// windowed-sinc coefficient generator; depends on nothing

`timescale 1ns / 1ps
`default_nettype none

package wfir_pkg;

    // field widths
    localparam int TAP_W      = 11;
    localparam int IDX_W      = 10;
    localparam int N2_W       = 12;
    localparam int CUT_W      = 16;
    localparam int COEF_W     = 18;
    localparam int DEN_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // design limits
    localparam int MAX_TAPS       = 1024;
    localparam int COEF_FRAC_BITS = 16;

    // pipeline depths of the shared arithmetic units
    localparam int SIN_LAT = 5;
    localparam int QDIV_NW = 60;
    localparam int PDIV_NW = IDX_W + 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_KIND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_KIND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_HIGH = 3'd4;

    // window codes
    localparam logic [1:0] WIN_BLACKMAN = 2'd0;
    localparam logic [1:0] WIN_HANNING  = 2'd1;
    localparam logic [1:0] WIN_HAMMING  = 2'd2;
    localparam logic [1:0] WIN_ZERO     = 2'd3;

    // filter codes
    localparam logic [1:0] FLT_LOWPASS  = 2'd0;
    localparam logic [1:0] FLT_HIGHPASS = 2'd1;
    localparam logic [1:0] FLT_BANDSTOP = 2'd2;
    localparam logic [1:0] FLT_BANDPASS = 2'd3;

    // q30 constants
    localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
    localparam logic signed [63:0] SIN_A       = 64'sd1686629713;
    localparam logic signed [63:0] SIN_B       = 64'sd688904866;
    localparam logic signed [63:0] SIN_C       = 64'sd76016977;
    localparam logic signed [63:0] TWO_OVER_PI = 64'sd683565276;
    localparam logic signed [63:0] K042        = 64'sd450971566;
    localparam logic signed [63:0] K050        = 64'sd536870912;
    localparam logic signed [63:0] K008        = 64'sd85899346;
    localparam logic signed [63:0] K054        = 64'sd579820585;
    localparam logic signed [63:0] K046        = 64'sd493921239;

    // classified request handed from front to back
    typedef struct packed {
        logic [IDX_W-1:0]       tap_index;
        logic [TAP_W-1:0]       m;
        logic signed [N2_W-1:0] n2;
        logic                   delta;
        logic                   err;
    } t_item;

    // filter settings used by the back end
    typedef struct packed {
        logic [1:0]       window_kind;
        logic [1:0]       filter_kind;
        logic [CUT_W-1:0] cutoff_low;
        logic [CUT_W-1:0] cutoff_high;
    } t_cfg;

endpackage

`default_nettype wire

@@ design/wfir_sin.sv @@
// wfir_sin: five-stage polynomial sine of a q0.32 turn angle, q30 result
// depends on wfir_pkg for the polynomial constants

`timescale 1ns / 1ps
`default_nettype none

module wfir_sin (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [31:0]        i_phase,
    output logic signed [31:0]      o_sin
);
    import wfir_pkg::*;

    logic [31:0]        n_q;
    logic signed [63:0] n_zz;
    logic signed [63:0] n_t1;
    logic signed [63:0] n_t2;
    logic signed [63:0] n_zt;
    logic signed [31:0] r_z1;
    logic signed [31:0] r_z2;
    logic signed [31:0] r_z3;
    logic signed [31:0] r_z4;
    logic signed [31:0] r_zsq2;
    logic signed [31:0] r_zsq3;
    logic signed [31:0] r_t1;
    logic signed [31:0] r_t2;
    logic signed [31:0] r_s;

    // fold the angle into the quarter turn around zero
    always_comb begin
        if (i_phase >= 32'h4000_0000 && i_phase < 32'hC000_0000) begin
            n_q = 32'h8000_0000 - i_phase;
        end else begin
            n_q = i_phase;
        end
    end

    // polynomial terms, one multiply per stage
    assign n_zz = r_z1 * r_z1;
    assign n_t1 = SIN_B - ((r_zsq2 * SIN_C) >>> 30);
    assign n_t2 = SIN_A - ((r_t1 * r_zsq3) >>> 30);
    assign n_zt = (r_z4 * r_t2) >>> 30;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1   <= n_q;
            r_z2   <= r_z1;
            r_zsq2 <= n_zz[61:30];
            r_z3   <= r_z2;
            r_zsq3 <= r_zsq2;
            r_t1   <= n_t1[31:0];
            r_z4   <= r_z3;
            r_t2   <= n_t2[31:0];
            r_s    <= n_zt[31:0];
        end
    end

    assign o_sin = r_s;

endmodule

`default_nettype wire

@@ design/wfir_div.sv @@
// wfir_div: pipelined restoring divider, one quotient bit per stage
// standalone, no package needed

`timescale 1ns / 1ps
`default_nettype none

module wfir_div #(
    parameter int NUM_W = 60,
    parameter int DEN_W = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0]      o_quo
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];

    // each stage shifts in one numerator bit and tries a subtract
    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] s_rem;
        logic [DEN_W-1:0] s_den;
        logic [NUM_W-1:0] s_nq;
        logic [DEN_W:0]   n_sh;
        logic [DEN_W:0]   n_diff;
        logic             n_ge;

        if (k == 0) begin : g_first
            assign s_rem = '0;
            assign s_den = i_den;
            assign s_nq  = i_num;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_den = r_den[k-1];
            assign s_nq  = r_nq[k-1];
        end

        assign n_sh   = {s_rem, s_nq[NUM_W-1]};
        assign n_diff = n_sh - {1'b0, s_den};
        assign n_ge   = n_sh >= {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? n_diff[DEN_W-1:0] : n_sh[DEN_W-1:0];
                r_den[k] <= s_den;
                r_nq[k]  <= {s_nq[NUM_W-2:0], n_ge};
            end
        end
    end

    assign o_quo = r_nq[NUM_W-1];

endmodule

`default_nettype wire

@@ design/wfir_dly.sv @@
// wfir_dly: enabled shift line that keeps side data aligned with the units
// standalone, no package needed

`timescale 1ns / 1ps
`default_nettype none

module wfir_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0]      o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    // shift one place per enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

`default_nettype wire

@@ design/wfir_front.sv @@
// wfir_front: accepts tap indexes, checks range, derives center terms,
// and buffers them in a two-entry queue; depends on wfir_pkg

`timescale 1ns / 1ps
`default_nettype none

module wfir_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire logic [wfir_pkg::IDX_W-1:0]  i_tap_index,
    input  wire logic [wfir_pkg::TAP_W-1:0]  i_tap_count,
    output logic                             o_full,
    input  wire logic                        i_take,
    output logic                             o_valid,
    output wfir_pkg::t_item                  o_item
);
    import wfir_pkg::*;

    logic [TAP_W-1:0] n_neff;
    logic [TAP_W-1:0] n_m;
    t_item            n_item;
    logic             n_wr;
    logic             n_rd;
    t_item            r_q [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    // clamp tap count and classify the index
    always_comb begin
        if (32'(i_tap_count) > MAX_TAPS) begin
            n_neff = TAP_W'(MAX_TAPS);
        end else begin
            n_neff = i_tap_count;
        end
        n_m              = n_neff - TAP_W'(1);
        n_item.tap_index = i_tap_index;
        n_item.m         = n_m;
        n_item.n2        = $signed({1'b0, i_tap_index, 1'b0}) - $signed({1'b0, n_m});
        n_item.delta     = {1'b0, i_tap_index} == (n_m >> 1);
        n_item.err       = {1'b0, i_tap_index} >= n_neff;
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_q[r_rp];
    assign n_wr    = i_push && !o_full;
    assign n_rd    = i_take && o_valid;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_q[r_wp] <= n_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_wr) begin
                r_wp <= !r_wp;
            end
            if (n_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, n_wr} - {1'b0, n_rd};
        end
    end

endmodule

`default_nettype wire

@@ design/wfir_back.sv @@
// wfir_back: sinc, window and filter arithmetic pipeline with output queue
// depends on wfir_pkg, wfir_sin, wfir_div and wfir_dly

`timescale 1ns / 1ps
`default_nettype none

module wfir_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire wfir_pkg::t_cfg               i_cfg,
    input  wire logic                         i_valid,
    input  wire wfir_pkg::t_item              i_item,
    output logic                              o_take,
    output logic                              o_empty,
    input  wire logic                         i_pop,
    output logic signed [wfir_pkg::COEF_W-1:0] o_coefficient,
    output logic                              o_index_error
);
    import wfir_pkg::*;

    // stage where each value sits, counted from the input register
    localparam int T_NUM  = 1 + SIN_LAT + 1;
    localparam int T_Q    = T_NUM + QDIV_NW;
    localparam int T_SINC = T_Q + 1;
    localparam int T_W    = PDIV_NW + SIN_LAT + 2;
    localparam int T_LP   = T_SINC + 1;
    localparam int T_OUT  = T_LP + 2;
    localparam int SH     = 30 - COEF_FRAC_BITS;
    localparam int VAL_W  = 36;
    localparam logic signed [VAL_W-1:0] SAT_HI = (VAL_W'(1) << (COEF_W - 1)) - VAL_W'(1);
    localparam logic signed [VAL_W-1:0] SAT_LO = -(VAL_W'(1) << (COEF_W - 1));

    function automatic logic signed [31:0] sinc_fix(input logic [QDIV_NW-1:0] q,
                                                   input logic neg, input logic zero,
                                                   input logic [CUT_W-1:0] cut);
        logic signed [31:0] mag;
        mag = $signed({2'b0, q[QDIV_NW-1:30]});
        if (zero) begin
            sinc_fix = $signed({1'b0, cut, 15'b0});
        end else if (neg) begin
            sinc_fix = -$signed({2'b0, q[QDIV_NW-1:30]}) - $signed({31'b0, |q[29:0]});
        end else begin
            sinc_fix = mag;
        end
    endfunction

    logic                    en;
    logic [T_OUT:0]          r_vld;
    t_item                   r_s0;
    logic signed [28:0]      n_pl;
    logic signed [28:0]      n_ph;
    logic [31:0]             r_ang_l;
    logic [31:0]             r_ang_h;
    logic signed [31:0]      s_l;
    logic signed [31:0]      s_h;
    logic signed [63:0]      r_num_l;
    logic signed [63:0]      r_num_h;
    logic signed [63:0]      n_neg_l;
    logic signed [63:0]      n_neg_h;
    logic [QDIV_NW-1:0]      n_mag_l;
    logic [QDIV_NW-1:0]      n_mag_h;
    logic                    d_n2zero_a;
    logic signed [N2_W-1:0]  d_n2;
    logic [N2_W-1:0]         n_n2_neg;
    logic [DEN_W-1:0]        n_den_q;
    logic                    n_sgn_l;
    logic                    n_sgn_h;
    logic [QDIV_NW-1:0]      q_l;
    logic [QDIV_NW-1:0]      q_h;
    logic                    d_n2zero_b;
    logic                    d_sgn_l;
    logic                    d_sgn_h;
    logic signed [31:0]      r_sinc_l;
    logic signed [31:0]      r_sinc_h;
    logic [DEN_W-1:0]        n_den_p;
    logic [PDIV_NW-1:0]      q_p;
    logic                    d_mzero;
    logic [31:0]             n_ph1;
    logic signed [31:0]      c1;
    logic signed [31:0]      c2;
    logic signed [63:0]      n_p1;
    logic signed [63:0]      n_p2;
    logic signed [63:0]      n_p3;
    logic signed [32:0]      r_p1;
    logic signed [32:0]      r_p2;
    logic signed [32:0]      r_p3;
    logic signed [32:0]      r_w;
    logic [32:0]             d_w_raw;
    logic signed [32:0]      d_w;
    logic signed [64:0]      n_prod_l;
    logic signed [64:0]      n_prod_h;
    logic signed [33:0]      r_lp_l;
    logic signed [33:0]      r_lp_h;
    logic                    d_delta;
    logic                    d_err;
    logic signed [VAL_W-1:0] n_lpl;
    logic signed [VAL_W-1:0] n_lph;
    logic signed [VAL_W-1:0] n_dl;
    logic signed [VAL_W-1:0] r_v;
    logic                    r_err_v;
    logic signed [VAL_W-1:0] n_vr;
    logic signed [VAL_W-1:0] n_sat;
    logic signed [COEF_W-1:0] r_coef;
    logic                    r_err_o;
    logic                    n_oq_wr;
    logic                    n_oq_rd;
    logic signed [COEF_W-1:0] r_oq_coef [2];
    logic                    r_oq_err [2];
    logic                    r_oq_wp;
    logic                    r_oq_rp;
    logic [1:0]              r_oq_cnt;

    // whole pipeline advances while the output queue has room
    assign en     = r_oq_cnt != 2'd2;
    assign o_take = en && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[T_OUT-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= i_item;
        end
    end

    // sinc angles
    assign n_pl = $signed({1'b0, i_cfg.cutoff_low}) * r_s0.n2;
    assign n_ph = $signed({1'b0, i_cfg.cutoff_high}) * r_s0.n2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang_l <= {n_pl[16:0], 15'b0};
            r_ang_h <= {n_ph[16:0], 15'b0};
        end
    end

    wfir_sin u_sin_l (.i_clk(i_clk), .i_en(en), .i_phase(r_ang_l), .o_sin(s_l));
    wfir_sin u_sin_h (.i_clk(i_clk), .i_en(en), .i_phase(r_ang_h), .o_sin(s_h));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_l <= s_l * TWO_OVER_PI;
            r_num_h <= s_h * TWO_OVER_PI;
        end
    end

    wfir_dly #(.WIDTH(N2_W + 1), .DEPTH(T_NUM)) u_dly_n2 (
        .i_clk(i_clk), .i_en(en), .i_d({r_s0.n2 == '0, r_s0.n2}),
        .o_q({d_n2zero_a, d_n2})
    );

    // sign and magnitude split for the sinc division
    always_comb begin
        n_neg_l  = -r_num_l;
        n_neg_h  = -r_num_h;
        n_mag_l  = r_num_l[63] ? n_neg_l[QDIV_NW-1:0] : r_num_l[QDIV_NW-1:0];
        n_mag_h  = r_num_h[63] ? n_neg_h[QDIV_NW-1:0] : r_num_h[QDIV_NW-1:0];
        n_n2_neg = -d_n2;
        if (d_n2zero_a) begin
            n_den_q = DEN_W'(1);
        end else if (d_n2[N2_W-1]) begin
            n_den_q = n_n2_neg[DEN_W-1:0];
        end else begin
            n_den_q = d_n2[DEN_W-1:0];
        end
        n_sgn_l = r_num_l[63] ^ d_n2[N2_W-1];
        n_sgn_h = r_num_h[63] ^ d_n2[N2_W-1];
    end

    wfir_div #(.NUM_W(QDIV_NW), .DEN_W(DEN_W)) u_div_l (
        .i_clk(i_clk), .i_en(en), .i_num(n_mag_l), .i_den(n_den_q), .o_quo(q_l)
    );
    wfir_div #(.NUM_W(QDIV_NW), .DEN_W(DEN_W)) u_div_h (
        .i_clk(i_clk), .i_en(en), .i_num(n_mag_h), .i_den(n_den_q), .o_quo(q_h)
    );
    wfir_dly #(.WIDTH(3), .DEPTH(QDIV_NW)) u_dly_sgn (
        .i_clk(i_clk), .i_en(en), .i_d({d_n2zero_a, n_sgn_l, n_sgn_h}),
        .o_q({d_n2zero_b, d_sgn_l, d_sgn_h})
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sinc_l <= sinc_fix(q_l, d_sgn_l, d_n2zero_b, i_cfg.cutoff_low);
            r_sinc_h <= sinc_fix(q_h, d_sgn_h, d_n2zero_b, i_cfg.cutoff_high);
        end
    end

    // window phase i / (N - 1) of a turn
    assign n_den_p = (r_s0.m == '0) ? DEN_W'(1) : r_s0.m;

    wfir_div #(.NUM_W(PDIV_NW), .DEN_W(DEN_W)) u_div_p (
        .i_clk(i_clk), .i_en(en), .i_num({r_s0.tap_index, 32'b0}), .i_den(n_den_p),
        .o_quo(q_p)
    );
    wfir_dly #(.WIDTH(1), .DEPTH(PDIV_NW)) u_dly_mz (
        .i_clk(i_clk), .i_en(en), .i_d(r_s0.m == '0), .o_q(d_mzero)
    );

    assign n_ph1 = d_mzero ? 32'b0 : q_p[31:0];

    wfir_sin u_cos_1 (
        .i_clk(i_clk), .i_en(en), .i_phase(n_ph1 + 32'h4000_0000), .o_sin(c1)
    );
    wfir_sin u_cos_2 (
        .i_clk(i_clk), .i_en(en), .i_phase({n_ph1[30:0], 1'b0} + 32'h4000_0000),
        .o_sin(c2)
    );

    // window terms
    assign n_p1 = (K050 * c1) >>> 30;
    assign n_p2 = (K008 * c2) >>> 30;
    assign n_p3 = (K046 * c1) >>> 30;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1 <= n_p1[32:0];
            r_p2 <= n_p2[32:0];
            r_p3 <= n_p3[32:0];
            unique case (i_cfg.window_kind)
                WIN_BLACKMAN: r_w <= $signed(K042[32:0]) - r_p1 + r_p2;
                WIN_HANNING:  r_w <= $signed(K050[32:0]) - r_p1;
                WIN_HAMMING:  r_w <= $signed(K054[32:0]) - r_p3;
                default:      r_w <= '0;
            endcase
        end
    end

    wfir_dly #(.WIDTH(33), .DEPTH(T_SINC - T_W)) u_dly_w (
        .i_clk(i_clk), .i_en(en), .i_d(r_w), .o_q(d_w_raw)
    );
    assign d_w = $signed(d_w_raw);

    // windowed lowpass prototypes
    assign n_prod_l = r_sinc_l * d_w;
    assign n_prod_h = r_sinc_h * d_w;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lp_l <= n_prod_l[63:30];
            r_lp_h <= n_prod_h[63:30];
        end
    end

    wfir_dly #(.WIDTH(2), .DEPTH(T_LP)) u_dly_flag (
        .i_clk(i_clk), .i_en(en), .i_d({r_s0.delta, r_s0.err}), .o_q({d_delta, d_err})
    );

    // filter combination
    assign n_lpl = {{(VAL_W - 34){r_lp_l[33]}}, r_lp_l};
    assign n_lph = {{(VAL_W - 34){r_lp_h[33]}}, r_lp_h};
    assign n_dl  = d_delta ? ONE_Q30[VAL_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_err_v <= d_err;
            unique case (i_cfg.filter_kind)
                FLT_LOWPASS:  r_v <= n_lpl;
                FLT_HIGHPASS: r_v <= n_dl - n_lpl;
                FLT_BANDSTOP: r_v <= n_lpl + n_dl - n_lph;
                default:      r_v <= n_lph - n_lpl;
            endcase
        end
    end

    // round half up to the output fraction
    if (SH == 0) begin : g_nornd
        assign n_vr = r_v;
    end else begin : g_rnd
        localparam logic signed [VAL_W-1:0] RND_HALF = VAL_W'(1) << (SH - 1);
        assign n_vr = (r_v + RND_HALF) >>> SH;
    end

    always_comb begin
        priority if (n_vr > SAT_HI) begin
            n_sat = SAT_HI;
        end else if (n_vr < SAT_LO) begin
            n_sat = SAT_LO;
        end else begin
            n_sat = n_vr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_err_o <= r_err_v;
            r_coef  <= r_err_v ? '0 : n_sat[COEF_W-1:0];
        end
    end

    // two-entry output queue
    assign n_oq_wr = en && r_vld[T_OUT];
    assign n_oq_rd = i_pop && (r_oq_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (n_oq_wr) begin
            r_oq_coef[r_oq_wp] <= r_coef;
            r_oq_err[r_oq_wp]  <= r_err_o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (n_oq_wr) begin
                r_oq_wp <= !r_oq_wp;
            end
            if (n_oq_rd) begin
                r_oq_rp <= !r_oq_rp;
            end
            r_oq_cnt <= r_oq_cnt + {1'b0, n_oq_wr} - {1'b0, n_oq_rd};
        end
    end

    assign o_empty       = r_oq_cnt == 2'd0;
    assign o_coefficient = r_oq_coef[r_oq_rp];
    assign o_index_error = r_oq_err[r_oq_rp];

    // checks
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt != 2'd3) else $error("output queue overflow");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oq_cnt == 2'd2 && !i_pop) |=> $stable(r_vld))
        else $error("pipeline moved while output queue full");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[T_OUT] && r_err_o) |-> (r_coef == '0))
        else $error("out of range index with nonzero coefficient");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oq_cnt == 2'd0 && !r_vld[T_OUT]) |=> (r_oq_cnt == 2'd0))
        else $error("result appeared without a pipeline transaction");

endmodule

`default_nettype wire

@@ design/windowed_sinc_fir_coefficient_generator_unit.sv @@
// windowed_sinc_fir_coefficient_generator_unit: top level with config registers
// depends on wfir_pkg, wfir_front and wfir_back
// throughput: one transaction per cycle through the 60-stage sinc divider pipeline when not held
// the whole back pipeline holds while its two-entry output queue is full
// reset (synchronous, active low) empties both queues and loads register defaults

`timescale 1ns / 1ps
`default_nettype none

module windowed_sinc_fir_coefficient_generator_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [wfir_pkg::IDX_W-1:0]        i_tap_index,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic signed [wfir_pkg::COEF_W-1:0]     o_coefficient,
    output logic                                   o_index_error,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [wfir_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [wfir_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import wfir_pkg::*;

    logic [TAP_W-1:0] r_tap_count;
    t_cfg             r_cfg;
    logic             take;
    logic             f_valid;
    t_item            f_item;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count       <= TAP_W'(64);
            r_cfg.window_kind <= WIN_BLACKMAN;
            r_cfg.filter_kind <= FLT_LOWPASS;
            r_cfg.cutoff_low  <= CUT_W'(8192);
            r_cfg.cutoff_high <= CUT_W'(16384);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TAP_COUNT:   r_tap_count       <= i_cfg_data[TAP_W-1:0];
                CFG_WINDOW_KIND: r_cfg.window_kind <= i_cfg_data[1:0];
                CFG_FILTER_KIND: r_cfg.filter_kind <= i_cfg_data[1:0];
                CFG_CUTOFF_LOW:  r_cfg.cutoff_low  <= i_cfg_data;
                CFG_CUTOFF_HIGH: r_cfg.cutoff_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wfir_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_tap_index (i_tap_index),
        .i_tap_count (r_tap_count),
        .o_full      (full),
        .i_take      (take),
        .o_valid     (f_valid),
        .o_item      (f_item)
    );

    wfir_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (f_valid),
        .i_item        (f_item),
        .o_take        (take),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_coefficient (o_coefficient),
        .o_index_error (o_index_error)
    );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// tb_top: self-checking testbench of the windowed-sinc coefficient generator
// depends on wfir_pkg and windowed_sinc_fir_coefficient_generator_unit

`timescale 1ns / 1ps

module tb_top;
    import wfir_pkg::*;

    // one expected coefficient transaction
    typedef struct {
        logic signed [COEF_W-1:0] coef;
        logic                     err;
    } t_coef_result;

    // register copy, fixed-point coefficient predictor and expected-result queue
    class coef_scoreboard;
        int unsigned tap_count = 64;
        bit [1:0]    window_kind = WIN_BLACKMAN;
        bit [1:0]    filter_kind = FLT_LOWPASS;
        int unsigned cutoff_low = 8192;
        int unsigned cutoff_high = 16384;
        t_coef_result pending_coefs[$];
        int errors = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TAP_COUNT:   tap_count = data[TAP_W-1:0];
                CFG_WINDOW_KIND: window_kind = data[1:0];
                CFG_FILTER_KIND: filter_kind = data[1:0];
                CFG_CUTOFF_LOW:  cutoff_low = data;
                CFG_CUTOFF_HIGH: cutoff_high = data;
                default: ;
            endcase
        endfunction

        // sine of a q0.32 turn angle, q30 result
        function longint sine_q30(bit [31:0] p);
            bit [31:0] q;
            longint z, z2, t;
            q = p;
            if (p >= 32'h4000_0000 && p < 32'hC000_0000) q = 32'h8000_0000 - p;
            z = $signed(q);
            z2 = (z * z) >>> 30;
            t = SIN_B - ((SIN_C * z2) >>> 30);
            t = SIN_A - ((t * z2) >>> 30);
            return (z * t) >>> 30;
        endfunction

        function longint cosine_q30(bit [31:0] p);
            return sine_q30(p + 32'h4000_0000);
        endfunction

        // windowed-sinc lowpass tap in q30
        function longint lowpass_q30(int unsigned i, int unsigned n, int unsigned c);
            bit [31:0] m, ang, ph1, ph2;
            bit [63:0] prod, num64;
            longint n2, sinc, w, c1;
            m = n - 1;
            n2 = 2 * longint'(i) - longint'(m);
            if (n2 == 0) begin
                sinc = longint'(c) << 15;
            end else begin
                prod = longint'(c) * n2;
                ang = {prod[16:0], 15'b0};
                sinc = ((sine_q30(ang) * TWO_OVER_PI) / n2) >>> 30;
            end
            ph1 = 0;
            if (m != 0) begin
                num64 = longint'(i) << 32;
                num64 = num64 / m;
                ph1 = num64[31:0];
            end
            ph2 = ph1 * 2;
            c1 = cosine_q30(ph1);
            case (window_kind)
                WIN_BLACKMAN: w = K042 - ((K050 * c1) >>> 30)
                                  + ((K008 * cosine_q30(ph2)) >>> 30);
                WIN_HANNING:  w = K050 - ((K050 * c1) >>> 30);
                WIN_HAMMING:  w = K054 - ((K046 * c1) >>> 30);
                default:      w = 0;
            endcase
            return (sinc * w) >>> 30;
        endfunction

        function void note_input(int unsigned idx);
            t_coef_result r;
            int unsigned n;
            longint dlt, v;
            n = (tap_count > MAX_TAPS) ? MAX_TAPS : tap_count;
            if (idx >= n) begin
                r.coef = '0;
                r.err = 1'b1;
            end else begin
                dlt = (idx == (n - 1) / 2) ? ONE_Q30 : 0;
                case (filter_kind)
                    FLT_LOWPASS:  v = lowpass_q30(idx, n, cutoff_low);
                    FLT_HIGHPASS: v = dlt - lowpass_q30(idx, n, cutoff_low);
                    FLT_BANDSTOP: v = lowpass_q30(idx, n, cutoff_low) + dlt
                                      - lowpass_q30(idx, n, cutoff_high);
                    default:      v = lowpass_q30(idx, n, cutoff_high)
                                      - lowpass_q30(idx, n, cutoff_low);
                endcase
                v = (v + (longint'(1) << (29 - COEF_FRAC_BITS))) >>> (30 - COEF_FRAC_BITS);
                if (v > 131071) v = 131071;
                if (v < -131072) v = -131072;
                r.coef = v[COEF_W-1:0];
                r.err = 1'b0;
            end
            pending_coefs.push_back(r);
        endfunction

        function void check_result(logic signed [COEF_W-1:0] coef, logic err);
            t_coef_result r;
            if (pending_coefs.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            r = pending_coefs.pop_front();
            if (coef !== r.coef) begin
                $error("coefficient expected %0d got %0d", r.coef, coef);
                errors++;
            end
            if (err !== r.err) begin
                $error("index_error expected %0d got %0d", r.err, err);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic [IDX_W-1:0]        i_tap_index;
    logic                    empty;
    logic                    pop;
    logic signed [COEF_W-1:0] o_coefficient;
    logic                    o_index_error;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    coef_scoreboard sb = new();
    bit quiet = 0;
    int stall_cnt = 0;
    int idle_cycles = 0;

    windowed_sinc_fir_coefficient_generator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_tap_index(i_tap_index),
        .empty(empty), .pop(pop),
        .o_coefficient(o_coefficient), .o_index_error(o_index_error),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // monitor: note inputs and check results at the edge they are accepted
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) sb.note_input(i_tap_index);
        if (i_rst_n && pop && !empty) sb.check_result(o_coefficient, o_index_error);
    end

    // watchdog on cycles with no transaction of any kind
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= 3000) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: pop with random stall bursts
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_cnt > 0) begin
                stall_cnt--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_cnt = $urandom_range(1, 13) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // one input transaction, optionally after an idle burst
    task automatic send_tap(int unsigned idx);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_tap_index <= idx[IDX_W-1:0];
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // stop sending and wait until every expected result has come
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_coefs.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data[CFG_DATA_W-1:0]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(int unsigned taps, bit [1:0] win, bit [1:0] flt,
                             int unsigned lo, int unsigned hi);
        drain();
        write_reg(CFG_TAP_COUNT, taps);
        write_reg(CFG_WINDOW_KIND, win);
        write_reg(CFG_FILTER_KIND, flt);
        write_reg(CFG_CUTOFF_LOW, lo);
        write_reg(CFG_CUTOFF_HIGH, hi);
    endtask

    // random indexes, mostly in range
    task automatic random_taps(int count);
        int unsigned n;
        n = (sb.tap_count > MAX_TAPS) ? MAX_TAPS : sb.tap_count;
        repeat (count) begin
            if (n > 0 && $urandom_range(0, 99) < 85) send_tap($urandom_range(0, n - 1));
            else send_tap($urandom_range(0, 1023));
        end
    endtask

    initial begin
        int unsigned taps;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_tap_index <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, center, ends, out of range
        send_tap(0); send_tap(31); send_tap(32); send_tap(63);
        send_tap(64); send_tap(1023); send_tap(512);
        // zero taps, single tap, two taps, clamped tap count, maximum and three taps
        configure(0, WIN_HANNING, FLT_HIGHPASS, 0, 32768);
        send_tap(0); send_tap(1);
        configure(1, WIN_HAMMING, FLT_BANDSTOP, 32768, 0);
        send_tap(0); send_tap(1);
        configure(2, WIN_ZERO, FLT_BANDPASS, 65535, 32768);
        send_tap(0); send_tap(1);
        configure(2047, WIN_BLACKMAN, FLT_BANDPASS, 4096, 32768);
        send_tap(0); send_tap(511); send_tap(512); send_tap(1023);
        configure(1024, WIN_HAMMING, FLT_HIGHPASS, 65535, 0);
        send_tap(0); send_tap(511); send_tap(1023);
        configure(3, WIN_HANNING, FLT_LOWPASS, 32768, 16384);
        send_tap(0); send_tap(1); send_tap(2); send_tap(3);

        // random phases, mostly small tap counts
        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 5))
                0:       taps = $urandom_range(0, 2047);
                1:       taps = $urandom_range(512, 1024);
                default: taps = $urandom_range(1, 96);
            endcase
            if (ph == 11) quiet = 1;
            configure(taps, $urandom_range(0, 3), $urandom_range(0, 3),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 32768),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 32768));
            random_taps(100);
        end

        // end of run
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_coefs.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.pending_coefs.size() != 0) sb.errors++;
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
